[hdl/ocrm_pkg.sv]
// ============================================================================
// ocrm_pkg - shared types and helpers for the orbital class reorder map
// Field structs, status codes and the per-group class boundary function.
// ============================================================================
`default_nettype none

package ocrm_pkg;

    localparam int MAX_GROUPS   = 8;
    localparam int MAX_ORBITALS = 1024;

    localparam int GROUP_W  = $clog2(MAX_GROUPS);       // group address
    localparam int GCOUNT_W = 4;                        // group_count register
    localparam int CNT_W    = 11;                       // one stored count
    localparam int IDX_W    = 10;                       // orbital index
    localparam int SUM_W    = 14;                       // sum of all totals
    localparam int CUM_W    = CNT_W + 1;                // class boundary
    localparam int NCLASS   = 5;
    localparam int CLS_W    = 3;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_COUNTS = 2'd1,
        ST_CORE   = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        op_t                operation;
        logic [GROUP_W-1:0] group;
        logic [CNT_W-1:0]   orbitals_in_group;
        logic [CNT_W-1:0]   doubly_occupied;
        logic [CNT_W-1:0]   singly_occupied;
        logic [CNT_W-1:0]   frozen_core;
        logic [CNT_W-1:0]   frozen_virtual;
        logic [IDX_W-1:0]   source_index;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] target_index;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] dbl;
        logic [CNT_W-1:0] sgl;
        logic [CNT_W-1:0] core;
        logic [CNT_W-1:0] fvirt;
    } group_counts_t;

    typedef struct packed {
        logic busy;     // sequencer not idle
        logic done;     // result waiting in sequencer
    } seq_status_t;

    typedef logic [NCLASS-1:0][CUM_W-1:0] cum_set_t;

    // Upper boundaries of the five classes inside one group:
    // core, doubly, doubly+singly, total-frozen virtual, total.
    function automatic cum_set_t ocrm_cum(input group_counts_t gc);
        cum_set_t r;
        r[0] = {1'b0, gc.core};
        r[1] = {1'b0, gc.dbl};
        r[2] = {1'b0, gc.dbl} + {1'b0, gc.sgl};
        r[3] = {1'b0, gc.total} - {1'b0, gc.fvirt};
        r[4] = {1'b0, gc.total};
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/ocrm_store.sv]
// ============================================================================
// ocrm_store - per-group count registers
// Eight entries of five counts, cleared by reset, one write and one read port.
// ============================================================================
`default_nettype none

module ocrm_store (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [ocrm_pkg::GROUP_W-1:0]  wr_group,
    input  wire ocrm_pkg::group_counts_t       wr_counts,
    input  wire logic [ocrm_pkg::GROUP_W-1:0]  rd_group,
    output ocrm_pkg::group_counts_t            rd_counts
);
    import ocrm_pkg::*;

    group_counts_t store_reg [MAX_GROUPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            store_reg[wr_group] <= wr_counts;
        end
    end

    assign rd_counts = store_reg[rd_group];

endmodule

`default_nettype wire

[hdl/ocrm_seq.sv]
// ============================================================================
// ocrm_seq - query sequencer
// Walks the groups once to check counts and locate the index; if that passes,
// picks the class, then walks the groups again accumulating the class-major position.
// ============================================================================
`default_nettype none

module ocrm_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ocrm_pkg::IDX_W-1:0]    source_index,
    input  wire logic [ocrm_pkg::GCOUNT_W-1:0] group_count,
    input  wire logic                          take,
    input  wire ocrm_pkg::group_counts_t       rd_counts,
    output logic [ocrm_pkg::GROUP_W-1:0]       rd_group,
    output ocrm_pkg::seq_status_t              seq_status,
    output ocrm_pkg::result_t                  result
);
    import ocrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CLASS,
        S_ACCUM,
        S_DONE
    } state_t;

    state_t              state_reg,    state_next;
    logic [GROUP_W-1:0]  grp_reg,      grp_next;
    logic [GROUP_W-1:0]  gsel_reg,     gsel_next;
    logic                found_reg,    found_next;
    logic                bad_cnt_reg,  bad_cnt_next;
    logic                bad_core_reg, bad_core_next;
    logic [SUM_W-1:0]    sum_reg,      sum_next;
    logic [IDX_W-1:0]    src_reg,      src_next;
    logic [CNT_W-1:0]    local_reg,    local_next;
    logic [CLS_W-1:0]    cls_reg,      cls_next;
    logic [IDX_W-1:0]    pos_reg,      pos_next;
    status_t             stat_reg,     stat_next;

    logic [GCOUNT_W-1:0] n_eff;
    logic [GROUP_W-1:0]  last_grp;
    cum_set_t            cum;
    logic [CNT_W+1:0]    occ_sum;
    logic                bad_cnt_now;
    logic [SUM_W-1:0]    sum_new;
    logic [SUM_W-1:0]    src_ext;
    logic                hit;
    logic [CLS_W-1:0]    cls_prev;
    logic [CUM_W-1:0]    prev_cum;
    logic [CLS_W-1:0]    cls_find;
    logic [CUM_W-1:0]    local_ext;
    logic [CUM_W-1:0]    rank;
    logic [CUM_W-1:0]    add_val;
    logic                f_cnt, f_core, f_found;

    assign n_eff    = (group_count > GCOUNT_W'(MAX_GROUPS)) ? GCOUNT_W'(MAX_GROUPS)
                                                            : group_count;
    assign last_grp = GROUP_W'(n_eff - GCOUNT_W'(1));
    assign rd_group = grp_reg;

    assign cum         = ocrm_cum(rd_counts);
    assign occ_sum     = {2'b0, rd_counts.dbl} + {2'b0, rd_counts.sgl}
                       + {2'b0, rd_counts.fvirt};
    assign bad_cnt_now = occ_sum > {2'b0, rd_counts.total};
    assign sum_new     = sum_reg + SUM_W'(rd_counts.total);
    assign src_ext     = SUM_W'(src_reg);
    assign hit         = !found_reg && (src_ext < sum_new);
    assign local_ext   = CUM_W'(local_reg);

    // class of the located orbital inside its group
    always_comb
    begin
        if (local_ext < cum[0])
            cls_find = CLS_W'(0);
        else if (local_ext < cum[1])
            cls_find = CLS_W'(1);
        else if (local_ext < cum[2])
            cls_find = CLS_W'(2);
        else if (local_ext < cum[3])
            cls_find = CLS_W'(3);
        else
            cls_find = CLS_W'(4);
    end

    // boundary below the class: during CLASS from cls_find, else cls_reg
    assign cls_prev = ((state_reg == S_CLASS) ? cls_find : cls_reg) - CLS_W'(1);
    always_comb
    begin
        if (((state_reg == S_CLASS) ? cls_find : cls_reg) == '0)
            prev_cum = '0;
        else
            prev_cum = cum[cls_prev];
    end

    assign rank    = local_ext - prev_cum;
    assign add_val = (grp_reg < gsel_reg) ? cum[cls_reg] : prev_cum;

    assign f_cnt   = bad_cnt_reg  | bad_cnt_now;
    assign f_core  = bad_core_reg | (rd_counts.core > rd_counts.dbl);
    assign f_found = found_reg | hit;

    always_comb
    begin
        state_next    = state_reg;
        grp_next      = grp_reg;
        gsel_next     = gsel_reg;
        found_next    = found_reg;
        bad_cnt_next  = bad_cnt_reg;
        bad_core_next = bad_core_reg;
        sum_next      = sum_reg;
        src_next      = src_reg;
        local_next    = local_reg;
        cls_next      = cls_reg;
        pos_next      = pos_reg;
        stat_next     = stat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    src_next      = source_index;
                    grp_next      = '0;
                    sum_next      = '0;
                    found_next    = 1'b0;
                    bad_cnt_next  = 1'b0;
                    bad_core_next = 1'b0;
                    pos_next      = '0;
                    if (n_eff == '0)
                    begin
                        stat_next  = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                bad_cnt_next  = f_cnt;
                bad_core_next = f_core;
                sum_next      = sum_new;
                found_next    = f_found;
                if (hit)
                begin
                    gsel_next  = grp_reg;
                    local_next = CNT_W'(src_ext - sum_reg);
                end
                if (grp_reg == last_grp)
                begin
                    if (f_cnt)
                    begin
                        stat_next  = ST_COUNTS;
                        state_next = S_DONE;
                    end
                    else if (f_core)
                    begin
                        stat_next  = ST_CORE;
                        state_next = S_DONE;
                    end
                    else if (sum_new > SUM_W'(MAX_ORBITALS))
                    begin
                        stat_next  = ST_COUNTS;
                        state_next = S_DONE;
                    end
                    else if (!f_found)
                    begin
                        stat_next  = ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        grp_next   = hit ? grp_reg : gsel_reg;
                        state_next = S_CLASS;
                    end
                end
                else
                begin
                    grp_next = grp_reg + GROUP_W'(1);
                end
            end

            S_CLASS:
            begin
                cls_next   = cls_find;
                pos_next   = rank[IDX_W-1:0];
                grp_next   = '0;
                state_next = S_ACCUM;
            end

            S_ACCUM:
            begin
                pos_next = pos_reg + add_val[IDX_W-1:0];
                if (grp_reg == last_grp)
                begin
                    stat_next  = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    grp_next = grp_reg + GROUP_W'(1);
                end
            end

            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            grp_reg      <= '0;
            found_reg    <= 1'b0;
            bad_cnt_reg  <= 1'b0;
            bad_core_reg <= 1'b0;
            stat_reg     <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            grp_reg      <= grp_next;
            found_reg    <= found_next;
            bad_cnt_reg  <= bad_cnt_next;
            bad_core_reg <= bad_core_next;
            stat_reg     <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gsel_reg  <= gsel_next;
        sum_reg   <= sum_next;
        src_reg   <= src_next;
        local_reg <= local_next;
        cls_reg   <= cls_next;
        pos_reg   <= pos_next;
    end

    assign seq_status.busy     = (state_reg != S_IDLE);
    assign seq_status.done     = (state_reg == S_DONE);
    assign result.target_index = pos_reg;
    assign result.status       = stat_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("query started while sequencer busy");

    a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACCUM |-> grp_reg <= last_grp)
        else $error("accumulate walked past last group");

    a_ok_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && stat_reg == ST_OK) |-> found_reg)
        else $error("ok result without a located group");

    a_class_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLASS |-> $past(state_reg) == S_SCAN)
        else $error("class step not entered from scan");
`endif

endmodule

`default_nettype wire

[hdl/orbital_class_reorder_map.sv]
// ============================================================================
// orbital_class_reorder_map - group-major to class-major orbital index map
// Holds per-group orbital counts and translates query indices into the
// frozen core / doubly / singly / virtual / frozen virtual ordering.
// ============================================================================
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  item     | in        | item_valid/stall    | item_t: load counts or query
//  result   | out       | result_valid/stall  | result_t: target_index,status
//  cfg      | in        | cfg_valid/ready     | group_count (4 bits)
//
//  Load: the transfer writes the group's counts directly.
//  Query: the sequencer makes one pass over the count registers of the
//  groups in use for checks and group search, one class step, and one
//  pass to sum the position; error results leave after the first pass.
//  The single group-read port and its adder set the per-group step.
//  Reset clears all counts and sets group_count to 1. The result register
//  frees the sequencer as soon as it loads; a stalled result holds.
// ============================================================================
`default_nettype none

module orbital_class_reorder_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire ocrm_pkg::item_t               item,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output ocrm_pkg::result_t                  result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ocrm_pkg::GCOUNT_W-1:0] cfg_data
);
    import ocrm_pkg::*;

    logic [GCOUNT_W-1:0] group_count_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;

    logic                item_xfer;
    logic                load_en;
    logic                query_start;
    logic                take;
    group_counts_t       wr_counts;
    group_counts_t       rd_counts;
    logic [GROUP_W-1:0]  rd_group;
    seq_status_t         seq_status;
    result_t             seq_result;

    // configuration must only be written while idle (the block does not enforce this), so always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            group_count_reg <= GCOUNT_W'(1);
        else if (cfg_valid && cfg_ready)
            group_count_reg <= cfg_data;
    end

    // one item at a time: stall while a query is in the sequencer
    assign item_stall  = seq_status.busy;
    assign item_xfer   = item_valid && !item_stall;
    assign load_en     = item_xfer && (item.operation == OP_LOAD);
    assign query_start = item_xfer && (item.operation == OP_QUERY);

    assign wr_counts.total = item.orbitals_in_group;
    assign wr_counts.dbl   = item.doubly_occupied;
    assign wr_counts.sgl   = item.singly_occupied;
    assign wr_counts.core  = item.frozen_core;
    assign wr_counts.fvirt = item.frozen_virtual;

    ocrm_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_en),
        .wr_group  (item.group),
        .wr_counts (wr_counts),
        .rd_group  (rd_group),
        .rd_counts (rd_counts)
    );

    ocrm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (query_start),
        .source_index (item.source_index),
        .group_count  (group_count_reg),
        .take         (take),
        .rd_counts    (rd_counts),
        .rd_group     (rd_group),
        .seq_status   (seq_status),
        .result       (seq_result)
    );

    // result register: loads when empty or being drained this cycle
    assign take = seq_status.done && (!out_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= seq_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_start |=> seq_status.busy)
        else $error("query transfer did not start the sequencer");

    a_take_space: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!out_valid_reg || !result_stall))
        else $error("result register overwritten while stalled");

    a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !seq_status.busy && out_valid_reg)
        else $error("result handoff did not free the sequencer");
`endif

endmodule

`default_nettype wire

[dv/testbench.sv]
// ============================================================================
// testbench - orbital class reorder map
// Drives count loads and index queries through the item channel, writes
// group_count through the config port between phases, and checks every
// result against an in-bench model of the group-major to class-major map.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    import ocrm_pkg::*;

    // Covers any item still in flight once the last expected result has arrived.
    localparam int DRAIN_CYCLES = 40;

    // Orbital classes in class-major order.
    typedef enum int {
        CLASS_CORE,
        CLASS_DOUBLE,
        CLASS_SINGLE,
        CLASS_VIRTUAL,
        CLASS_FROZEN_VIRTUAL
    } orbital_class_e;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    item_t               item_bus     = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    result_t             result_bus;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [GCOUNT_W-1:0] cfg_data     = '0;

    orbital_class_reorder_map u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model state: a copy of the count store and group_count, as after reset.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]    count_total  [MAX_GROUPS] = '{default: '0};
    logic [CNT_W-1:0]    count_double [MAX_GROUPS] = '{default: '0};
    logic [CNT_W-1:0]    count_single [MAX_GROUPS] = '{default: '0};
    logic [CNT_W-1:0]    count_core   [MAX_GROUPS] = '{default: '0};
    logic [CNT_W-1:0]    count_fvirt  [MAX_GROUPS] = '{default: '0};
    logic [GCOUNT_W-1:0] map_groups = GCOUNT_W'(1);

    result_t pending_results[$];     // expected results, oldest first

    bit quiet = 1'b0;                // set: neither side idles nor stalls
    int error_count   = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int cfg_writes    = 0;
    int status_seen[4] = '{default: 0};

    // group_count above MAX_GROUPS behaves as MAX_GROUPS
    function automatic int unsigned groups_in_use();
        return (map_groups > MAX_GROUPS) ? MAX_GROUPS : map_groups;
    endfunction

    // Sum of totals over groups in use, leaving out group skip
    // (skip = MAX_GROUPS leaves out nothing).
    function automatic int unsigned orbitals_in_use(input int unsigned skip);
        int unsigned sum;
        sum = 0;
        for (int unsigned k = 0; k < groups_in_use(); k++)
            if (k != skip)
                sum += count_total[k];
        return sum;
    endfunction

    // Size of one class inside one group. Only meaningful for groups whose
    // counts passed both consistency checks.
    function automatic int unsigned class_size(input int unsigned g, input int unsigned k);
        case (k)
            CLASS_CORE:    return count_core[g];
            CLASS_DOUBLE:  return int'(count_double[g]) - count_core[g];
            CLASS_SINGLE:  return count_single[g];
            CLASS_VIRTUAL: return int'(count_total[g]) - count_double[g]
                                  - count_single[g] - count_fvirt[g];
            default:       return count_fvirt[g];
        endcase
    endfunction

    // Applies one accepted item to the model. Loads update the store and
    // return 0; queries return 1 with the expected result in r.
    function automatic bit class_major_lookup(input item_t it, output result_t r);
        int unsigned n, s, sum, base, g, cls, rank, pos;
        r.target_index = '0;
        r.status       = ST_OK;
        if (it.operation == OP_LOAD) begin
            count_total[it.group]  = it.orbitals_in_group;
            count_double[it.group] = it.doubly_occupied;
            count_single[it.group] = it.singly_occupied;
            count_core[it.group]   = it.frozen_core;
            count_fvirt[it.group]  = it.frozen_virtual;
            return 1'b0;
        end
        n   = groups_in_use();
        s   = it.source_index;
        sum = 0;
        // status priority: bad counts in any group, then core > doubly,
        // then a total above MAX_ORBITALS, then the index range
        for (int unsigned k = 0; k < n; k++) begin
            if (int'(count_double[k]) + count_single[k] + count_fvirt[k] > count_total[k]) begin
                r.status = ST_COUNTS;
                return 1'b1;
            end
            sum += count_total[k];
        end
        for (int unsigned k = 0; k < n; k++) begin
            if (count_core[k] > count_double[k]) begin
                r.status = ST_CORE;
                return 1'b1;
            end
        end
        if (sum > MAX_ORBITALS) begin
            r.status = ST_COUNTS;
            return 1'b1;
        end
        if (s >= sum) begin
            r.status = ST_RANGE;
            return 1'b1;
        end
        // group holding the index, then class and rank inside that group
        base = 0;
        g    = 0;
        while (g < n && s >= base + count_total[g]) begin
            base += count_total[g];
            g++;
        end
        rank = s - base;
        cls  = CLASS_CORE;
        while (cls < CLASS_FROZEN_VIRTUAL && rank >= class_size(g, cls)) begin
            rank -= class_size(g, cls);
            cls++;
        end
        // all earlier classes of every group, then this class in earlier groups
        pos = 0;
        for (int unsigned c = 0; c < n; c++) begin
            for (int unsigned k = 0; k < cls; k++)
                pos += class_size(c, k);
            if (c < g)
                pos += class_size(c, cls);
        end
        pos += rank;
        r.target_index = pos[IDX_W-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders. Fields the operation ignores carry random values.
    // ------------------------------------------------------------------------
    function automatic item_t load_item(input int unsigned g, input int unsigned t,
                                        input int unsigned d, input int unsigned s,
                                        input int unsigned c, input int unsigned v);
        item_t it;
        it                   = item_t'({$urandom, $urandom});
        it.operation         = OP_LOAD;
        it.group             = g[GROUP_W-1:0];
        it.orbitals_in_group = t[CNT_W-1:0];
        it.doubly_occupied   = d[CNT_W-1:0];
        it.singly_occupied   = s[CNT_W-1:0];
        it.frozen_core       = c[CNT_W-1:0];
        it.frozen_virtual    = v[CNT_W-1:0];
        return it;
    endfunction

    function automatic item_t query_item(input int unsigned idx);
        item_t it;
        it              = item_t'({$urandom, $urandom});
        it.operation    = OP_QUERY;
        it.source_index = idx[IDX_W-1:0];
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Item channel: one transfer per call. Valid stays high after the
    // transfer so back-to-back items see no bubble; idle gaps lower it.
    // ------------------------------------------------------------------------
    task automatic send_item(input item_t it);
        result_t r;
        while (!quiet && $urandom_range(99) < 6) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_bus   <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        if (class_major_lookup(it, r)) begin
            pending_results.push_back(r);
            queries_sent++;
            status_seen[r.status]++;
        end else begin
            loads_sent++;
        end
    endtask

    // Stops the sender until every expected result is back; with settle it
    // also lets trailing loads finish before a config write.
    task automatic wait_drained(input bit settle);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_group_count(input int unsigned value);
        wait_drained(1'b1);
        cfg_data  <= value[GCOUNT_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        map_groups = value[GCOUNT_W-1:0];
        cfg_writes++;
    endtask

    // Loads group g with counts that add up, total within budget.
    task automatic load_consistent(input int unsigned g, input int unsigned budget,
                                   output int unsigned t);
        int unsigned d, s, v;
        case ($urandom_range(3))
            0:       t = budget;
            1:       t = $urandom_range(0, budget);
            default: t = $urandom_range(0, (budget < 160) ? budget : 160);
        endcase
        d = $urandom_range(0, t);
        s = $urandom_range(0, t - d);
        v = $urandom_range(0, t - d - s);
        send_item(load_item(g, t, d, s, $urandom_range(0, d), v));
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stall, and a check of every transfer against
    // the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        result_t want;
        result_stall <= !quiet && ($urandom_range(99) < 6);
        if (rst_n && result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: target_index %0d status %0d",
                       result_bus.target_index, result_bus.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (result_bus.target_index !== want.target_index) begin
                    $error("target_index: expected %0d, got %0d",
                           want.target_index, result_bus.target_index);
                    error_count++;
                end
                if (result_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result_bus.status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Cleared store, one group in use: nothing is in range.
    task automatic test_reset_state();
        send_item(query_item(0));
        send_item(query_item(1023));
    endtask

    int unsigned int_list_bounds[8] = '{0, 49, 50, 399, 400, 499, 999, 1023};

    // One full group of 1024: probe both ends of core, doubly and singly, top end of the rest.
    // core 0..49, rest of doubly 50..399, singly 400..499,
    // virtual 500..999, frozen virtual 1000..1023
    task automatic test_single_group_bounds();
        send_item(load_item(0, 1024, 400, 100, 50, 24));
        foreach (int_list_bounds[i])
            send_item(query_item(int_list_bounds[i]));
    endtask

    // Status priority: bad sum beats core > doubly; then core alone;
    // then two groups whose totals together exceed MAX_ORBITALS.
    task automatic test_status_priority();
        send_item(load_item(0, 10, 6, 4, 7, 1));
        send_item(query_item(3));
        send_item(load_item(0, 10, 6, 2, 7, 0));
        send_item(query_item(3));
        send_item(load_item(0, 1024, 0, 0, 0, 0));
        write_group_count(2);
        send_item(load_item(1, 1, 0, 0, 0, 0));
        send_item(query_item(0));
    endtask

    // group_count 0 (no group in use), 15 (clamped to 8) and 8.
    task automatic test_group_count_extremes();
        write_group_count(0);
        send_item(query_item(0));
        write_group_count(15);
        send_item(query_item(5));
        send_item(load_item(1, 0, 0, 0, 0, 0));
        send_item(query_item(1023));
        write_group_count(8);
        send_item(query_item(512));
    endtask

    // ------------------------------------------------------------------------
    // Random phases: each picks a group_count, loads every group with counts
    // that fit in MAX_ORBITALS, then mixes mostly in-range queries with
    // reloads. Late in each phase some loads are raw noise, which drives the
    // error statuses. Mid-phase the sender drains the block completely.
    // ------------------------------------------------------------------------
    task automatic test_random_phases();
        int unsigned gc, budget, t, g, others, span;
        for (int phase = 0; phase < 16; phase++) begin
            case (phase)
                0:       gc = 1;
                1:       gc = 8;
                2:       gc = 15;
                3:       gc = 0;
                default: gc = ($urandom_range(9) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 8);
            endcase
            write_group_count(gc);
            quiet = (phase >= 6 && phase <= 8);

            budget = MAX_ORBITALS;
            for (int unsigned k = 0; k < MAX_GROUPS; k++) begin
                load_consistent(k, budget, t);
                if (k < groups_in_use())
                    budget -= t;
            end

            for (int i = 0; i < 55; i++) begin
                if (i == 27)
                    wait_drained(1'b0);
                if ($urandom_range(99) < 15) begin
                    g = $urandom_range(0, MAX_GROUPS - 1);
                    if (i >= 40 && $urandom_range(2) == 0) begin
                        send_item(load_item(g, $urandom_range(0, 2047),
                                            $urandom_range(0, 2047), $urandom_range(0, 2047),
                                            $urandom_range(0, 2047), $urandom_range(0, 2047)));
                    end else begin
                        others = orbitals_in_use(g);
                        load_consistent(g, (others >= MAX_ORBITALS) ? 0
                                           : MAX_ORBITALS - others, t);
                    end
                end else begin
                    span = orbitals_in_use(MAX_GROUPS);
                    if (span > MAX_ORBITALS)
                        span = MAX_ORBITALS;
                    if (span != 0 && $urandom_range(7) != 0)
                        send_item(query_item($urandom_range(0, span - 1)));
                    else
                        send_item(query_item($urandom_range(0, 1023)));
                end
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_single_group_bounds();
        test_status_priority();
        test_group_count_extremes();
        test_random_phases();

        // An expectation never met stalls here and ends in the timeout.
        wait_drained(1'b1);

        $display("Covered %0d loads and %0d queries across %0d group_count writes",
                 loads_sent, queries_sent, cfg_writes);
        $display("Query outcomes: %0d mapped, %0d bad counts, %0d bad core, %0d out of range",
                 status_seen[ST_OK], status_seen[ST_COUNTS], status_seen[ST_CORE],
                 status_seen[ST_RANGE]);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $error("timeout with %0d results outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hdl/ocrm_pkg.sv
hdl/ocrm_store.sv
hdl/ocrm_seq.sv
hdl/orbital_class_reorder_map.sv
dv/testbench.sv
